// File: hw/rtl/brhp_pkg.sv
// brhp_pkg: shared types, codes and character constants for the byte range parser
// used by brhp_parse, brhp_eval, byte_range_header_parser and brhp_checker
`default_nettype none

package brhp_pkg;

	localparam int SIZE_BITS = 48;

	typedef logic [SIZE_BITS-1:0] val_t;

	localparam val_t VAL_MAX = '1;

	// number field phases
	localparam logic [1:0] PH_SKIP   = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_STOP   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_WHOLE   = 2'd0;
	localparam logic [1:0] ST_PARTIAL = 2'd1;
	localparam logic [1:0] ST_UNSAT   = 2'd2;

	localparam logic [2:0] PREFIX_LEN = 3'd6;

	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [1:0] phase;
		val_t       value;
		logic       nonblank;
		logic       negative;
	} num_t;

	// parse result handed to the evaluation pipeline
	typedef struct packed {
		logic ok;
		logic first_nb;
		logic second_nb;
		val_t first_value;
		val_t second_value;
		val_t total;
		val_t total_m1;
	} snap_t;

	typedef struct packed {
		logic ok;
		logic total_zero;
		logic first_nb;
		logic second_nb;
		logic s_ge_total;
		val_t first_value;
		val_t total;
		val_t n;
		val_t e;
	} eval_t;

	// expected character of "bytes=" at a prefix position
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd0: ch = 8'h62;
			3'd1: ch = 8'h79;
			3'd2: ch = 8'h74;
			3'd3: ch = 8'h65;
			3'd4: ch = 8'h73;
			default: ch = 8'h3d;
		endcase
		return ch;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/brhp_parse.sv
// brhp_parse: per-beat prefix match and number accumulation state of the range parser
// depends on brhp_pkg; gives the parse snapshot of the beat being accepted
`default_nettype none

module brhp_parse (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire logic [7:0]      header_byte,
	input  wire logic            last_byte,
	input  wire logic            empty_value,
	input  wire brhp_pkg::val_t  total_size,
	output brhp_pkg::snap_t      snap
);

	logic [2:0]     pos_q, pos_n;
	logic           failed_q, failed_n;
	logic           comma_q, comma_n;
	logic           dash_q, dash_n;
	brhp_pkg::num_t first_q, first_n;
	brhp_pkg::num_t second_q, second_n;

	function automatic brhp_pkg::num_t feed_number(input logic [7:0] c,
		input brhp_pkg::num_t cur);
		brhp_pkg::num_t                r;
		logic                          digit;
		logic [3:0]                    d;
		logic [brhp_pkg::SIZE_BITS+3:0] acc;
		r     = cur;
		digit = (c >= brhp_pkg::CH_ZERO) && (c <= brhp_pkg::CH_NINE);
		d     = c[3:0];
		acc   = {1'b0, cur.value, 3'b000} + {3'b000, cur.value, 1'b0} +
			(brhp_pkg::SIZE_BITS+4)'(d);
		if (c != brhp_pkg::CH_SPACE && c != brhp_pkg::CH_TAB)
			r.nonblank = 1'b1;
		unique case (cur.phase)
			brhp_pkg::PH_SKIP: begin
				if (brhp_pkg::is_space(c)) begin
					r.phase = brhp_pkg::PH_SKIP;
				end else if (c == brhp_pkg::CH_PLUS) begin
					r.phase = brhp_pkg::PH_SIGN;
				end else if (c == brhp_pkg::CH_DASH) begin
					r.phase    = brhp_pkg::PH_SIGN;
					r.negative = 1'b1;
				end else if (digit) begin
					r.value = brhp_pkg::SIZE_BITS'(d);
					r.phase = brhp_pkg::PH_DIGITS;
				end else begin
					r.phase = brhp_pkg::PH_STOP;
				end
			end
			brhp_pkg::PH_SIGN: begin
				if (digit) begin
					r.value = brhp_pkg::SIZE_BITS'(d);
					r.phase = brhp_pkg::PH_DIGITS;
				end else begin
					r.phase = brhp_pkg::PH_STOP;
				end
			end
			brhp_pkg::PH_DIGITS: begin
				if (digit) begin
					// saturate when value*10+d leaves the field
					if (|acc[brhp_pkg::SIZE_BITS+3:brhp_pkg::SIZE_BITS])
						r.value = brhp_pkg::VAL_MAX;
					else
						r.value = acc[brhp_pkg::SIZE_BITS-1:0];
				end else begin
					r.phase = brhp_pkg::PH_STOP;
				end
			end
			default: begin
				r.phase = cur.phase;
			end
		endcase
		return r;
	endfunction

	always_comb begin
		pos_n    = pos_q;
		failed_n = failed_q;
		comma_n  = comma_q;
		dash_n   = dash_q;
		first_n  = first_q;
		second_n = second_q;
		if (header_byte == brhp_pkg::CH_COMMA)
			comma_n = 1'b1;
		if (!failed_q) begin
			if (pos_q < brhp_pkg::PREFIX_LEN) begin
				if (header_byte == brhp_pkg::prefix_char(pos_q))
					pos_n = pos_q + 3'd1;
				else
					failed_n = 1'b1;
			end else if (!dash_q) begin
				if (header_byte == brhp_pkg::CH_DASH)
					dash_n = 1'b1;
				else
					first_n = feed_number(header_byte, first_q);
			end else begin
				second_n = feed_number(header_byte, second_q);
			end
		end
	end

	always_comb begin
		snap.ok = !failed_n && (pos_n == brhp_pkg::PREFIX_LEN) && !comma_n && dash_n &&
			!empty_value;
		snap.first_nb     = first_n.nonblank;
		snap.second_nb    = second_n.nonblank;
		snap.first_value  = first_n.value;
		// negative nonzero counts as saturated
		snap.second_value = (second_n.negative && (|second_n.value)) ?
			brhp_pkg::VAL_MAX : second_n.value;
		snap.total        = total_size;
		snap.total_m1     = total_size - brhp_pkg::SIZE_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			failed_q <= 1'b0;
			comma_q  <= 1'b0;
			dash_q   <= 1'b0;
			first_q  <= '0;
			second_q <= '0;
		end else if (take) begin
			if (last_byte || empty_value) begin
				pos_q    <= '0;
				failed_q <= 1'b0;
				comma_q  <= 1'b0;
				dash_q   <= 1'b0;
				first_q  <= '0;
				second_q <= '0;
			end else begin
				pos_q    <= pos_n;
				failed_q <= failed_n;
				comma_q  <= comma_n;
				dash_q   <= dash_n;
				first_q  <= first_n;
				second_q <= second_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/brhp_eval.sv
// brhp_eval: two-stage range evaluation (clamp and compare, then subtract) with output register
// depends on brhp_pkg; fed by the parse snapshot stage of the top level
`default_nettype none

module brhp_eval (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            snap_valid,
	input  wire brhp_pkg::snap_t snap,
	output logic                 snap_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [1:0]           status,
	output brhp_pkg::val_t       range_start,
	output brhp_pkg::val_t       range_length
);

	brhp_pkg::eval_t ev_next, ev_s3;
	logic            valid_s3;
	logic            out_free;
	logic            out_valid_q;
	logic [1:0]      status_q, status_n;
	brhp_pkg::val_t  start_q, start_n;
	brhp_pkg::val_t  length_q, length_n;
	brhp_pkg::val_t  tail_start, span;
	logic            e_lt_s;

	assign out_free   = !out_valid_q || out_ready;
	assign snap_ready = !valid_s3 || out_free;

	always_comb begin
		ev_next.ok          = snap.ok;
		ev_next.total_zero  = (snap.total == '0);
		ev_next.first_nb    = snap.first_nb;
		ev_next.second_nb   = snap.second_nb;
		ev_next.s_ge_total  = (snap.first_value >= snap.total);
		ev_next.first_value = snap.first_value;
		ev_next.total       = snap.total;
		ev_next.n           = (snap.second_value < snap.total) ? snap.second_value : snap.total;
		ev_next.e           = (snap.second_nb && (snap.second_value < snap.total_m1)) ?
			snap.second_value : snap.total_m1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (snap_ready)
			valid_s3 <= snap_valid;
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready)
			ev_s3 <= ev_next;
	end

	assign tail_start = ev_s3.total - ev_s3.n;
	assign span       = ev_s3.e - ev_s3.first_value + brhp_pkg::SIZE_BITS'(1);
	assign e_lt_s     = (ev_s3.e < ev_s3.first_value);

	always_comb begin
		status_n = brhp_pkg::ST_WHOLE;
		start_n  = '0;
		length_n = ev_s3.total;
		if (ev_s3.ok) begin
			priority if (ev_s3.total_zero) begin
				status_n = brhp_pkg::ST_UNSAT;
			end else if (!ev_s3.first_nb) begin
				// suffix form
				if (ev_s3.second_nb) begin
					if (ev_s3.n == '0) begin
						status_n = brhp_pkg::ST_UNSAT;
					end else begin
						status_n = brhp_pkg::ST_PARTIAL;
						start_n  = tail_start;
						length_n = ev_s3.n;
					end
				end
			end else if (ev_s3.s_ge_total || e_lt_s) begin
				status_n = brhp_pkg::ST_UNSAT;
			end else begin
				status_n = brhp_pkg::ST_PARTIAL;
				start_n  = ev_s3.first_value;
				length_n = span;
			end
		end
		if (status_n == brhp_pkg::ST_UNSAT) begin
			start_n  = '0;
			length_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && out_free) begin
			status_q <= status_n;
			start_q  <= start_n;
			length_q <= length_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign range_start  = start_q;
	assign range_length = length_q;

endmodule

`default_nettype wire

// File: hw/rtl/byte_range_header_parser.sv
// byte_range_header_parser: top level of the single byte-range Range header parser
// depends on brhp_pkg, brhp_parse and brhp_eval
//
// The input channel carries one character of the header value per beat, with last_byte
// on the final character and total_size valid on that beat. A beat with empty_value set
// stands for an absent or empty header and ends the value at once. Every final or empty
// beat gives exactly one result beat on the output channel (status, range_start,
// range_length); other beats give none.
// Throughput is one beat per cycle while in_ready is high: the parse state advances on
// every accepted beat and the accumulate (times ten plus digit, with saturation)
// finishes in that cycle. After the final beat is accepted, its result passes through a
// snapshot stage, a clamp/compare stage and a subtract stage that loads the output
// register. The stages hold results independently, so input beats keep flowing while a
// result waits; in_ready drops only when all three result stages are full and out_ready
// is low.
// Reset clears the parse state and all stage valids; no result is pending after reset,
// and every result also returns the parse state to its reset value.
`default_nettype none

module byte_range_header_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     header_byte,
	input  wire logic           last_byte,
	input  wire logic           empty_value,
	input  wire brhp_pkg::val_t total_size,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [1:0]          status,
	output brhp_pkg::val_t      range_start,
	output brhp_pkg::val_t      range_length
);

	brhp_pkg::snap_t snap_next, snap_s2;
	logic            valid_s2;
	logic            snap_ready;
	logic            take;
	logic            produce;

	assign produce  = last_byte | empty_value;
	assign in_ready = !valid_s2 || snap_ready;
	assign take     = in_valid && in_ready;

	brhp_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.header_byte (header_byte),
		.last_byte   (last_byte),
		.empty_value (empty_value),
		.total_size  (total_size),
		.snap        (snap_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (in_ready)
			valid_s2 <= take && produce;
	end

	always_ff @(posedge clk) begin
		if (take && produce)
			snap_s2 <= snap_next;
	end

	brhp_eval u_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_valid   (valid_s2),
		.snap         (snap_s2),
		.snap_ready   (snap_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.range_start  (range_start),
		.range_length (range_length)
	);

endmodule

`default_nettype wire

// File: hw/rtl/brhp_checker.sv
// brhp_checker: port-level assertions on the result channel of the range parser
// depends on brhp_pkg; bound to byte_range_header_parser at the end of this file
`default_nettype none

module brhp_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire logic [1:0]     status,
	input wire brhp_pkg::val_t range_start,
	input wire brhp_pkg::val_t range_length
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(range_start) && $stable(range_length))
		else $error("result beat changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == brhp_pkg::ST_WHOLE) || (status == brhp_pkg::ST_PARTIAL) ||
		(status == brhp_pkg::ST_UNSAT))
		else $error("reserved status code");

	a_unsat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == brhp_pkg::ST_UNSAT) |-> (range_start == '0) &&
		(range_length == '0))
		else $error("unsatisfiable result with nonzero range");

	a_whole_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == brhp_pkg::ST_WHOLE) |-> (range_start == '0))
		else $error("whole content with nonzero start");

	a_partial_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == brhp_pkg::ST_PARTIAL) |-> (range_length != '0))
		else $error("partial range with zero length");

endmodule

bind byte_range_header_parser brhp_checker u_brhp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.range_start  (range_start),
	.range_length (range_length)
);

`default_nettype wire

// File: test/byte_range_header_parser_tb.sv
// byte_range_header_parser_tb: self-checking bench for the single byte-range parser
// drives header beats with random gaps, predicts each range result and compares it
// depends on brhp_pkg and byte_range_header_parser
module byte_range_header_parser_tb;

	localparam int CLK_PERIOD = 4;
	localparam int RESET_CYCLES = 7;
	localparam int TIMEOUT_CYCLES = 300000;
	localparam int HOLD_CYCLES = 150;
	localparam int BEATS_PER_PHASE = 178;
	localparam int SETTLE_CYCLES = 10;
	localparam logic [47:0] UNIT_TEXT = "bytes=";

	typedef struct packed {
		logic [7:0]     ch;
		logic           fin;
		logic           no_value;
		brhp_pkg::val_t total;
	} header_beat_t;

	typedef struct packed {
		logic [1:0]     code;
		brhp_pkg::val_t offset;
		brhp_pkg::val_t count;
	} range_answer_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	logic [7:0]     header_byte = '0;
	logic           last_byte = 1'b0;
	logic           empty_value = 1'b0;
	brhp_pkg::val_t total_size = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	logic [1:0]     status;
	brhp_pkg::val_t range_start;
	brhp_pkg::val_t range_length;

	header_beat_t  beats_to_send[$];
	range_answer_t answers_due[$];
	logic [7:0]    text_buf[$];
	header_beat_t  beat_on_bus;

	// parse state kept in step with the block
	logic [2:0]     unit_pos;
	bit             unit_bad;
	bit             saw_comma;
	bit             saw_dash;
	brhp_pkg::num_t from_num;
	brhp_pkg::num_t to_num;

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic sink_hold = 1'b0;
	int   errors = 0;
	int   beats_in = 0;
	int   beats_queued = 0;
	int   ranges_checked = 0;
	int   whole_seen = 0;
	int   partial_seen = 0;
	int   unsat_seen = 0;
	int   in_stalls = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	byte_range_header_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.header_byte  (header_byte),
		.last_byte    (last_byte),
		.empty_value  (empty_value),
		.total_size   (total_size),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.range_start  (range_start),
		.range_length (range_length)
	);

	task automatic report_error(string what);
		errors++;
		$display("ERROR at %0t: %s", $time, what);
	endtask

	task automatic clear_parse();
		unit_pos = '0;
		unit_bad = 1'b0;
		saw_comma = 1'b0;
		saw_dash = 1'b0;
		from_num = '0;
		to_num = '0;
	endtask

	function automatic logic [7:0] unit_char(int pos);
		return UNIT_TEXT[8 * (5 - pos) +: 8];
	endfunction

	function automatic bit skippable(logic [7:0] c);
		return c == brhp_pkg::CH_SPACE || c == brhp_pkg::CH_TAB || c == brhp_pkg::CH_LF ||
			c == brhp_pkg::CH_VT || c == brhp_pkg::CH_FF || c == brhp_pkg::CH_CR;
	endfunction

	// strtoull-style digit accumulation with saturation
	function automatic brhp_pkg::num_t step_number(brhp_pkg::num_t n, logic [7:0] c);
		logic        digit;
		logic [63:0] grown;
		digit = (c >= brhp_pkg::CH_ZERO) && (c <= brhp_pkg::CH_NINE);
		grown = 64'(n.value) * 64'd10 + 64'(c - brhp_pkg::CH_ZERO);
		if (c != brhp_pkg::CH_SPACE && c != brhp_pkg::CH_TAB)
			n.nonblank = 1'b1;
		case (n.phase)
			brhp_pkg::PH_SKIP: begin
				if (!skippable(c)) begin
					if (c == brhp_pkg::CH_PLUS) begin
						n.phase = brhp_pkg::PH_SIGN;
					end else if (c == brhp_pkg::CH_DASH) begin
						n.phase = brhp_pkg::PH_SIGN;
						n.negative = 1'b1;
					end else if (digit) begin
						n.value = brhp_pkg::val_t'(c - brhp_pkg::CH_ZERO);
						n.phase = brhp_pkg::PH_DIGITS;
					end else begin
						n.phase = brhp_pkg::PH_STOP;
					end
				end
			end
			brhp_pkg::PH_SIGN: begin
				if (digit) begin
					n.value = brhp_pkg::val_t'(c - brhp_pkg::CH_ZERO);
					n.phase = brhp_pkg::PH_DIGITS;
				end else begin
					n.phase = brhp_pkg::PH_STOP;
				end
			end
			brhp_pkg::PH_DIGITS: begin
				if (!digit)
					n.phase = brhp_pkg::PH_STOP;
				else if (grown > 64'(brhp_pkg::VAL_MAX))
					n.value = brhp_pkg::VAL_MAX;
				else
					n.value = grown[brhp_pkg::SIZE_BITS-1:0];
			end
			default: ;
		endcase
		return n;
	endfunction

	task automatic take_char(logic [7:0] c);
		if (c == brhp_pkg::CH_COMMA)
			saw_comma = 1'b1;
		if (!unit_bad) begin
			if (unit_pos < brhp_pkg::PREFIX_LEN) begin
				if (c == unit_char(unit_pos))
					unit_pos = unit_pos + 3'd1;
				else
					unit_bad = 1'b1;
			end else if (!saw_dash) begin
				if (c == brhp_pkg::CH_DASH)
					saw_dash = 1'b1;
				else
					from_num = step_number(from_num, c);
			end else begin
				to_num = step_number(to_num, c);
			end
		end
	endtask

	function automatic range_answer_t resolve_range(brhp_pkg::val_t total);
		range_answer_t  a;
		brhp_pkg::val_t upper;
		brhp_pkg::val_t n;
		brhp_pkg::val_t stop;
		a.code = brhp_pkg::ST_WHOLE;
		a.offset = '0;
		a.count = total;
		if (!unit_bad && unit_pos == brhp_pkg::PREFIX_LEN && !saw_comma && saw_dash) begin
			upper = (to_num.negative && to_num.value != '0) ? brhp_pkg::VAL_MAX :
				to_num.value;
			if (total == '0) begin
				a.code = brhp_pkg::ST_UNSAT;
			end else if (!from_num.nonblank) begin
				if (to_num.nonblank) begin
					n = (upper < total) ? upper : total;
					if (n == '0) begin
						a.code = brhp_pkg::ST_UNSAT;
					end else begin
						a.code = brhp_pkg::ST_PARTIAL;
						a.offset = total - n;
						a.count = n;
					end
				end
			end else begin
				stop = total - 1'b1;
				if (to_num.nonblank && upper < stop)
					stop = upper;
				if (from_num.value >= total || stop < from_num.value) begin
					a.code = brhp_pkg::ST_UNSAT;
				end else begin
					a.code = brhp_pkg::ST_PARTIAL;
					a.offset = from_num.value;
					a.count = stop - from_num.value + 1'b1;
				end
			end
		end
		if (a.code == brhp_pkg::ST_UNSAT) begin
			a.offset = '0;
			a.count = '0;
		end
		return a;
	endfunction

	task automatic parse_beat(header_beat_t b);
		range_answer_t a;
		if (b.no_value) begin
			a.code = brhp_pkg::ST_WHOLE;
			a.offset = '0;
			a.count = b.total;
			answers_due.insert(answers_due.size(), a);
			clear_parse();
		end else begin
			take_char(b.ch);
			if (b.fin) begin
				answers_due.insert(answers_due.size(), resolve_range(b.total));
				clear_parse();
			end
		end
	endtask

	task automatic check_range();
		range_answer_t want;
		if (answers_due.size() == 0) begin
			report_error($sformatf("unexpected result status %0d start %0d length %0d",
				status, range_start, range_length));
		end else begin
			want = answers_due.pop_front();
			ranges_checked++;
			if (want.code == brhp_pkg::ST_WHOLE)
				whole_seen++;
			else if (want.code == brhp_pkg::ST_PARTIAL)
				partial_seen++;
			else
				unsat_seen++;
			if (status !== want.code || range_start !== want.offset ||
				range_length !== want.count)
				report_error($sformatf(
					"range %0d: got status %0d start %0d length %0d, want %0d %0d %0d",
					ranges_checked, status, range_start, range_length,
					want.code, want.offset, want.count));
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				parse_beat(beat_on_bus);
				beats_in++;
			end
			if (in_valid && !in_ready)
				in_stalls++;
			if (!in_valid || in_ready) begin
				if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					beat_on_bus = beats_to_send.pop_front();
					in_valid <= 1'b1;
					header_byte <= beat_on_bus.ch;
					last_byte <= beat_on_bus.fin;
					empty_value <= beat_on_bus.no_value;
					total_size <= beat_on_bus.total;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_range();
			out_ready <= !sink_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic brhp_pkg::val_t rand_val();
		return brhp_pkg::val_t'({$urandom, $urandom});
	endfunction

	function automatic brhp_pkg::val_t rand_upto(logic [63:0] hi);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return brhp_pkg::val_t'(r % (hi + 64'd1));
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(5))
			0: return brhp_pkg::CH_SPACE;
			1: return brhp_pkg::CH_TAB;
			2: return brhp_pkg::CH_LF;
			3: return brhp_pkg::CH_VT;
			4: return brhp_pkg::CH_FF;
			default: return brhp_pkg::CH_CR;
		endcase
	endfunction

	function automatic brhp_pkg::val_t pick_total();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return brhp_pkg::val_t'($urandom_range(2000, 1));
		else if (r < 53)
			return '0;
		else if (r < 60)
			return brhp_pkg::VAL_MAX;
		else if (r < 65)
			return brhp_pkg::val_t'(1);
		return rand_val();
	endfunction

	task automatic push_beat(logic [7:0] ch, logic fin, logic no_value,
		brhp_pkg::val_t total);
		header_beat_t b;
		b.ch = ch;
		b.fin = fin;
		b.no_value = no_value;
		b.total = total;
		beats_to_send.insert(beats_to_send.size(), b);
		beats_queued++;
	endtask

	task automatic push_empty(brhp_pkg::val_t total);
		push_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, total);
	endtask

	task automatic put_char(logic [7:0] c);
		text_buf.insert(text_buf.size(), c);
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.insert(text_buf.size(), s[i]);
	endtask

	task automatic flush_value(brhp_pkg::val_t total, bit fin);
		int n;
		n = text_buf.size();
		for (int i = 0; i < n; i++) begin
			if (i == n - 1)
				push_beat(text_buf[i], fin, 1'b0, total);
			else
				push_beat(text_buf[i], 1'b0, 1'b0, rand_val());
		end
		text_buf.delete();
	endtask

	task automatic value_case(string s, brhp_pkg::val_t total);
		put_text(s);
		flush_value(total, 1'b1);
	endtask

	task automatic put_number(brhp_pkg::val_t total, bit second_part);
		int r;
		int n;
		r = $urandom_range(99);
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(2, 1);
			for (int k = 0; k < n; k++)
				put_char(pick_blank());
		end
		if ($urandom_range(9) == 0)
			put_char((second_part && $urandom_range(1) == 1) ? brhp_pkg::CH_DASH :
				brhp_pkg::CH_PLUS);
		if (r >= 12 && r < 18) begin
			n = $urandom_range(25, 15);
			for (int k = 0; k < n; k++)
				put_char(8'(brhp_pkg::CH_ZERO + $urandom_range(9)));
		end else if (r >= 18) begin
			if ($urandom_range(7) == 0)
				put_char(brhp_pkg::CH_ZERO);
			put_text($sformatf("%0d", rand_upto(64'(total) + 64'(total) / 4 + 64'd2)));
		end
		if ($urandom_range(9) == 0)
			put_char(8'($urandom_range(126, 33)));
	endtask

	// mostly well-formed values with random numbers, some noise and aborted values
	task automatic queue_random_value();
		int             kind;
		int             n;
		int             pos;
		brhp_pkg::val_t total;
		total = pick_total();
		kind = $urandom_range(99);
		if (kind < 6) begin
			push_empty(total);
		end else if (kind < 12) begin
			n = $urandom_range(12, 1);
			for (int k = 0; k < n; k++)
				put_char(8'($urandom_range(255)));
			flush_value(total, 1'b1);
		end else begin
			put_text("bytes=");
			if (kind < 18) begin
				pos = $urandom_range(5);
				if ($urandom_range(1) == 1)
					text_buf[pos] = 8'($urandom_range(255));
				else
					while (text_buf.size() > pos + 1)
						text_buf.delete(text_buf.size() - 1);
			end
			if ($urandom_range(3) != 0)
				put_number(total, 1'b0);
			if ($urandom_range(19) != 0)
				put_char(brhp_pkg::CH_DASH);
			if ($urandom_range(3) != 0)
				put_number(total, 1'b1);
			if ($urandom_range(19) == 0) begin
				put_char(brhp_pkg::CH_COMMA);
				put_number(total, 1'b0);
			end
			if (kind < 21) begin
				flush_value(total, 1'b0);
				push_empty(pick_total());
			end else begin
				flush_value(total, 1'b1);
			end
		end
	endtask

	task automatic queue_random(int beats);
		int target;
		target = beats_queued + beats;
		while (beats_queued < target)
			queue_random_value();
	endtask

	task automatic directed_cases();
		push_beat(8'h62, 1'b0, 1'b1, brhp_pkg::val_t'(1000));
		push_beat(8'hff, 1'b1, 1'b1, brhp_pkg::VAL_MAX);
		value_case("bytes=0-499", brhp_pkg::val_t'(1000));
		value_case("bytes=500-", brhp_pkg::val_t'(1000));
		value_case("bytes=-200", brhp_pkg::val_t'(1000));
		value_case("bytes=-2000", brhp_pkg::val_t'(1000));
		value_case("bytes=-0", brhp_pkg::val_t'(1000));
		value_case("bytes=0-99999", brhp_pkg::val_t'(1000));
		value_case("bytes=1000-", brhp_pkg::val_t'(1000));
		value_case("bytes=5-3", brhp_pkg::val_t'(1000));
		value_case("bytes=0-10", '0);
		value_case("bytes=-", brhp_pkg::val_t'(1000));
		value_case("bytes=0-1,2-3", brhp_pkg::val_t'(1000));
		value_case("Bytes=0-1", brhp_pkg::val_t'(1000));
		value_case("bytes", brhp_pkg::val_t'(1000));
		value_case("bytes=0", brhp_pkg::val_t'(1000));
		value_case("bytes=+5-+7", brhp_pkg::val_t'(1000));
		value_case("bytes=99999999999999999999-", brhp_pkg::VAL_MAX);
		value_case("bytes=0-99999999999999999999", brhp_pkg::VAL_MAX);
		value_case("bytes=281474976710654-", brhp_pkg::VAL_MAX);
		value_case("bytes=x-5", brhp_pkg::val_t'(1000));
		value_case("bytes=0-5x7", brhp_pkg::val_t'(1000));
		value_case("bytes=--", brhp_pkg::val_t'(1000));
		value_case("bytes=--5", brhp_pkg::val_t'(1000));
		// blank parts with space and tab
		put_text("bytes=");
		put_char(brhp_pkg::CH_SPACE);
		put_char(brhp_pkg::CH_TAB);
		put_char(brhp_pkg::CH_DASH);
		put_char(brhp_pkg::CH_TAB);
		put_char(brhp_pkg::CH_SPACE);
		flush_value(brhp_pkg::val_t'(1000), 1'b1);
		// other whitespace and a signed second number
		put_text("bytes=");
		put_char(brhp_pkg::CH_LF);
		put_char(brhp_pkg::CH_FF);
		put_text("3-");
		put_char(brhp_pkg::CH_CR);
		put_text("-4");
		flush_value(brhp_pkg::val_t'(1000), 1'b1);
		put_text("bytes=-");
		put_char(brhp_pkg::CH_VT);
		flush_value(brhp_pkg::val_t'(1000), 1'b1);
		put_text("bytes=5-");
		put_char(8'hff);
		flush_value(brhp_pkg::val_t'(1000), 1'b1);
		// partial value dropped by an empty beat
		put_text("bytes=1");
		flush_value(brhp_pkg::val_t'(1000), 1'b0);
		push_beat(8'h00, 1'b0, 1'b1, brhp_pkg::val_t'(77));
	endtask

	// sink holds off while the source keeps offering result-producing beats
	task automatic overfill_burst();
		fork
			begin
				sink_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold <= 1'b0;
			end
		join_none
		for (int k = 0; k < 12; k++) begin
			push_empty(brhp_pkg::val_t'(k + 1));
			value_case("bytes=-1", brhp_pkg::val_t'(9));
		end
	endtask

	task automatic wait_idle();
		while (beats_to_send.size() != 0 || in_valid || answers_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clear_parse();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 15;
		recv_idle_pct = 84;
		directed_cases();
		queue_random(BEATS_PER_PHASE);
		wait_idle();
		send_idle_pct = 84;
		recv_idle_pct = 15;
		queue_random(BEATS_PER_PHASE);
		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		overfill_burst();
		queue_random(BEATS_PER_PHASE);
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (answers_due.size() != 0)
			report_error($sformatf("%0d results never arrived", answers_due.size()));
		$display("covered %0d beats, %0d ranges: %0d whole, %0d partial, %0d unsatisfiable",
			beats_in, ranges_checked, whole_seen, partial_seen, unsat_seen);
		$display("input stalled %0d cycles, %0d mismatches", in_stalls, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
